/* rtl/rmq_pkg.sv */
// Shared types and constants for the rotation matrix to quaternion converter.
// No dependencies.
package rmq_pkg;

  localparam int DW   = 18;        // matrix entry / quaternion component width
  localparam int NW   = 19;        // off-diagonal sum or difference
  localparam int RW   = 21;        // signed radicand
  localparam int SW   = 19;        // root S = floor(sqrt(R * 2^18))
  localparam int RADW = 37;        // R * 2^18
  localparam int DIVW = 36;        // |D| * 2^16 + S/2
  localparam int QW   = 18;        // quotient bits kept before saturation
  localparam int QUEUE_DEPTH = 4;

  localparam logic signed [RW-1:0] Q_ONE   = RW'(65536);
  localparam logic signed [DW-1:0] OUT_MAX = DW'(131071);
  localparam logic signed [DW-1:0] OUT_MIN = -DW'(131072);

  localparam logic [1:0] CASE_TRACE = 2'd0;
  localparam logic [1:0] CASE_X     = 2'd1;
  localparam logic [1:0] CASE_Y     = 2'd2;
  localparam logic [1:0] CASE_Z     = 2'd3;

  // Classified transaction handed from front to back.
  typedef struct packed {
    logic signed [RW-1:0] rad;
    logic signed [NW-1:0] nw;
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic signed [NW-1:0] nz;
    logic [1:0]           which;
  } item_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic not_empty;
    logic almost_full;
  } qstat_t;

endpackage

/* rtl/rmq_front.sv */
// Front end: accepts a matrix, picks the Shepperd branch, forms radicand and numerators.
// Depends on rmq_pkg.
module rmq_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic signed [rmq_pkg::DW-1:0]    r00,
  input  logic signed [rmq_pkg::DW-1:0]    r01,
  input  logic signed [rmq_pkg::DW-1:0]    r02,
  input  logic signed [rmq_pkg::DW-1:0]    r10,
  input  logic signed [rmq_pkg::DW-1:0]    r11,
  input  logic signed [rmq_pkg::DW-1:0]    r12,
  input  logic signed [rmq_pkg::DW-1:0]    r20,
  input  logic signed [rmq_pkg::DW-1:0]    r21,
  input  logic signed [rmq_pkg::DW-1:0]    r22,
  output logic                             push,
  output rmq_pkg::item_t                   item
);

  localparam int RW = rmq_pkg::RW;
  localparam int NW = rmq_pkg::NW;

  logic signed [RW-1:0] a00, a11, a22, tr;
  logic signed [NW-1:0] d12, d20, d01, s01, s20, s12;
  rmq_pkg::item_t       item_nxt, item_r;
  logic                 push_r;

  always_comb begin
    a00 = RW'(r00);
    a11 = RW'(r11);
    a22 = RW'(r22);
    tr  = a00 + a11 + a22;
    d12 = NW'(r12) - NW'(r21);
    d20 = NW'(r20) - NW'(r02);
    d01 = NW'(r01) - NW'(r10);
    s01 = NW'(r01) + NW'(r10);
    s20 = NW'(r20) + NW'(r02);
    s12 = NW'(r12) + NW'(r21);
    item_nxt = '0;
    // strict compares: ties fall to the later branch
    priority if (tr > 0) begin
      item_nxt.which = rmq_pkg::CASE_TRACE;
      item_nxt.rad   = rmq_pkg::Q_ONE + tr;
      item_nxt.nx    = d12;
      item_nxt.ny    = d20;
      item_nxt.nz    = d01;
    end else if (r00 > r11 && r00 > r22) begin
      item_nxt.which = rmq_pkg::CASE_X;
      item_nxt.rad   = rmq_pkg::Q_ONE + a00 - a11 - a22;
      item_nxt.nw    = d12;
      item_nxt.ny    = s01;
      item_nxt.nz    = s20;
    end else if (r11 > r22) begin
      item_nxt.which = rmq_pkg::CASE_Y;
      item_nxt.rad   = rmq_pkg::Q_ONE + a11 - a00 - a22;
      item_nxt.nw    = d20;
      item_nxt.nx    = s01;
      item_nxt.nz    = s12;
    end else begin
      item_nxt.which = rmq_pkg::CASE_Z;
      item_nxt.rad   = rmq_pkg::Q_ONE + a22 - a00 - a11;
      item_nxt.nw    = d01;
      item_nxt.nx    = s20;
      item_nxt.ny    = s12;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      push_r <= 1'b0;
    end else begin
      push_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign push = push_r;
  assign item = item_r;

endmodule

/* rtl/rmq_queue.sv */
// Short queue between front and back end.
// Depends on rmq_pkg.
module rmq_queue #(
  parameter int DEPTH = rmq_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rmq_pkg::item_t  wr_item,
  input  logic            pop,
  output rmq_pkg::item_t  rd_item,
  output rmq_pkg::qstat_t stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  rmq_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_pop;

  assign do_pop = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    count_nxt  = count_r + CW'(push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  assign rd_item          = mem_r[rd_ptr_r];
  assign stat.not_empty   = (count_r != '0);
  assign stat.almost_full = (count_r >= CW'(DEPTH - 1));

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !do_pop && count_r == CW'(DEPTH)))
    else $error("queue written while full");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

/* rtl/rmq_back.sv */
// Back end: pipelined square root, four pipelined restoring dividers, saturation.
// Depends on rmq_pkg.
module rmq_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  rmq_pkg::item_t                in_item,
  output logic                          out_valid,
  output logic signed [rmq_pkg::DW-1:0] out_quat_w,
  output logic signed [rmq_pkg::DW-1:0] out_quat_x,
  output logic signed [rmq_pkg::DW-1:0] out_quat_y,
  output logic signed [rmq_pkg::DW-1:0] out_quat_z,
  output logic [1:0]                    out_case_taken,
  output logic                          out_degenerate
);

  localparam int DW   = rmq_pkg::DW;
  localparam int NW   = rmq_pkg::NW;
  localparam int SW   = rmq_pkg::SW;
  localparam int RADW = rmq_pkg::RADW;
  localparam int DIVW = rmq_pkg::DIVW;
  localparam int QW   = rmq_pkg::QW;
  localparam int LAT  = SW + QW + 2;

  typedef struct packed {
    logic                 degen;
    logic [1:0]           which;
    logic signed [NW-1:0] nw;
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic signed [NW-1:0] nz;
  } sq_ctl_t;

  typedef struct packed {
    logic            neg;
    logic            ovf;
    logic [DIVW-1:0] rem;
    logic [QW-1:0]   q;
  } lane_t;

  typedef struct packed {
    logic          degen;
    logic [1:0]    which;
    logic [SW-1:0] root;
  } dv_ctl_t;

  // ---------------- square root, one result bit per stage
  logic [SW-1:0]   sq_vld_r;
  sq_ctl_t         sq_ctl_r  [SW];
  logic [RADW-1:0] sq_rem_r  [SW];
  logic [SW-1:0]   sq_root_r [SW];
  sq_ctl_t         ctl0;
  logic [RADW-1:0] n0;

  always_comb begin
    ctl0.degen = (in_item.rad <= 0);
    ctl0.which = in_item.which;
    ctl0.nw    = in_item.nw;
    ctl0.nx    = in_item.nx;
    ctl0.ny    = in_item.ny;
    ctl0.nz    = in_item.nz;
    n0 = ctl0.degen ? '0 : {in_item.rad[SW-1:0], 18'b0};
  end

  for (genvar k = 0; k < SW; k++) begin : g_sq
    localparam int B = SW - 1 - k;
    logic [RADW-1:0] rem_in;
    logic [SW-1:0]   root_in;
    sq_ctl_t         ctl_in;
    logic            vld_in;
    logic [RADW:0]   trial;
    logic            take;

    if (k == 0) begin : g_first
      assign rem_in  = n0;
      assign root_in = '0;
      assign ctl_in  = ctl0;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign rem_in  = sq_rem_r[k-1];
      assign root_in = sq_root_r[k-1];
      assign ctl_in  = sq_ctl_r[k-1];
      assign vld_in  = sq_vld_r[k-1];
    end

    // (root + 2^B)^2 - root^2
    assign trial = ((RADW+1)'(root_in) << (B + 1)) + ((RADW+1)'(1) << (2 * B));
    assign take  = ({1'b0, rem_in} >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k] <= 1'b0;
      end else begin
        sq_vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      sq_rem_r[k]  <= take ? rem_in - trial[RADW-1:0] : rem_in;
      sq_root_r[k] <= take ? (root_in | (SW'(1) << B)) : root_in;
      sq_ctl_r[k]  <= ctl_in;
    end
  end

  // ---------------- divider setup and quotient steps
  logic [QW:0]   dv_vld_r;
  dv_ctl_t       dv_ctl_r  [QW+1];
  lane_t         dv_lane_r [QW+1][4];
  sq_ctl_t       sq_last;
  logic [SW-1:0] root_s;
  logic signed [NW-1:0] nums [4];

  assign sq_last = sq_ctl_r[SW-1];
  assign root_s  = sq_root_r[SW-1];
  assign nums[0] = sq_last.nw;
  assign nums[1] = sq_last.nx;
  assign nums[2] = sq_last.ny;
  assign nums[3] = sq_last.nz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else begin
      dv_vld_r[0] <= sq_vld_r[SW-1];
    end
  end

  always_ff @(posedge clk) begin
    dv_ctl_r[0].degen <= sq_last.degen;
    dv_ctl_r[0].which <= sq_last.which;
    dv_ctl_r[0].root  <= root_s;
  end

  for (genvar l = 0; l < 4; l++) begin : g_prep
    logic          neg;
    logic [NW-1:0] mag;
    assign neg = nums[l][NW-1];
    assign mag = neg ? NW'(-nums[l]) : NW'(nums[l]);
    always_ff @(posedge clk) begin
      dv_lane_r[0][l].neg <= neg;
      dv_lane_r[0][l].ovf <= 1'b0;
      dv_lane_r[0][l].rem <= (DIVW'(mag) << 16) + DIVW'(root_s >> 1);
      dv_lane_r[0][l].q   <= '0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_dv
    localparam int B = QW - 1 - j;
    logic [DIVW-1:0] dvs;

    assign dvs = DIVW'(dv_ctl_r[j].root) << B;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j+1] <= 1'b0;
      end else begin
        dv_vld_r[j+1] <= dv_vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      dv_ctl_r[j+1] <= dv_ctl_r[j];
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
      lane_t cur;
      logic  take;
      assign cur  = dv_lane_r[j][l];
      assign take = (cur.rem >= dvs);
      always_ff @(posedge clk) begin
        dv_lane_r[j+1][l].neg <= cur.neg;
        if (j == 0) begin
          // quotient of 2^QW or more saturates in either sign
          dv_lane_r[j+1][l].ovf <=
            ({1'b0, cur.rem} >= ((DIVW+1)'(dv_ctl_r[j].root) << QW));
        end else begin
          dv_lane_r[j+1][l].ovf <= cur.ovf;
        end
        dv_lane_r[j+1][l].rem <= take ? cur.rem - dvs : cur.rem;
        dv_lane_r[j+1][l].q   <= take ? (cur.q | (QW'(1) << B)) : cur.q;
      end
    end
  end

  // ---------------- component select and saturation
  function automatic logic signed [DW-1:0] lane_value(input lane_t ln);
    logic signed [DW:0] v;
    v = ln.neg ? -(DW+1)'(ln.q) : (DW+1)'(ln.q);
    if (ln.ovf) begin
      return ln.neg ? rmq_pkg::OUT_MIN : rmq_pkg::OUT_MAX;
    end else if (v > (DW+1)'(rmq_pkg::OUT_MAX)) begin
      return rmq_pkg::OUT_MAX;
    end else if (v < (DW+1)'(rmq_pkg::OUT_MIN)) begin
      return rmq_pkg::OUT_MIN;
    end
    return DW'(v);
  endfunction

  dv_ctl_t              fin;
  logic signed [DW-1:0] comp_nxt [4];
  logic signed [DW-1:0] comp_r   [4];
  logic                 valid_r, degen_r;
  logic [1:0]           case_r;

  assign fin = dv_ctl_r[QW];

  for (genvar l = 0; l < 4; l++) begin : g_out
    always_comb begin
      if (fin.degen) begin
        comp_nxt[l] = '0;
      end else if (fin.which == 2'(l)) begin
        comp_nxt[l] = DW'(fin.root >> 2);
      end else begin
        comp_nxt[l] = lane_value(dv_lane_r[QW][l]);
      end
    end
    always_ff @(posedge clk) begin
      comp_r[l] <= comp_nxt[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= dv_vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    degen_r <= fin.degen;
    case_r  <= fin.which;
  end

  assign out_valid      = valid_r;
  assign out_quat_w     = comp_r[0];
  assign out_quat_x     = comp_r[1];
  assign out_quat_y     = comp_r[2];
  assign out_quat_z     = comp_r[3];
  assign out_case_taken = case_r;
  assign out_degenerate = degen_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld |-> ##LAT out_valid)
    else $error("result strobe missing after fixed latency");
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_quat_w == '0 && out_quat_x == '0 && out_quat_y == '0 && out_quat_z == '0))
    else $error("degenerate result not zeroed");
  a_trace_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_case_taken == rmq_pkg::CASE_TRACE) |->
      (!out_degenerate && out_quat_w > 0))
    else $error("trace branch gave degenerate or non-positive w");
`endif

endmodule

/* rtl/rotation_matrix_to_quaternion.sv */
// Rotation matrix to quaternion converter, top level.
// Depends on rmq_pkg, rmq_front, rmq_queue, rmq_back.
//
// Converts a 3x3 rotation (signed Q2.16 entries) to a quaternion (w,x,y,z)
// in signed Q2.16 with the four-branch Shepperd method; components are
// saturated, and a non-positive radicand gives a zero quaternion with
// out_degenerate set. A transaction is taken when start is high and busy is
// low; one matrix per clock is sustained. Each result appears for one cycle
// with out_valid. The start edge itself registers the branch selection,
// then the transaction passes the queue register, 19 square-root stages (one
// root bit each), one divider setup stage, 18 quotient stages (one bit
// each) and the output register. Results cannot be held off; busy only
// rises if the queue nears full, which with a free-running back end does
// not happen.
module rotation_matrix_to_quaternion #(
  parameter int QUEUE_DEPTH = rmq_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [rmq_pkg::DW-1:0] in_r00,
  input  logic signed [rmq_pkg::DW-1:0] in_r01,
  input  logic signed [rmq_pkg::DW-1:0] in_r02,
  input  logic signed [rmq_pkg::DW-1:0] in_r10,
  input  logic signed [rmq_pkg::DW-1:0] in_r11,
  input  logic signed [rmq_pkg::DW-1:0] in_r12,
  input  logic signed [rmq_pkg::DW-1:0] in_r20,
  input  logic signed [rmq_pkg::DW-1:0] in_r21,
  input  logic signed [rmq_pkg::DW-1:0] in_r22,
  output logic                          out_valid,
  output logic signed [rmq_pkg::DW-1:0] out_quat_w,
  output logic signed [rmq_pkg::DW-1:0] out_quat_x,
  output logic signed [rmq_pkg::DW-1:0] out_quat_y,
  output logic signed [rmq_pkg::DW-1:0] out_quat_z,
  output logic [1:0]                    out_case_taken,
  output logic                          out_degenerate
);

  logic            accept, push;
  rmq_pkg::item_t  f_item, q_item;
  rmq_pkg::qstat_t q_stat;

  assign busy   = q_stat.almost_full;
  assign accept = start && !busy;

  rmq_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .r00    (in_r00),
    .r01    (in_r01),
    .r02    (in_r02),
    .r10    (in_r10),
    .r11    (in_r11),
    .r12    (in_r12),
    .r20    (in_r20),
    .r21    (in_r21),
    .r22    (in_r22),
    .push   (push),
    .item   (f_item)
  );

  rmq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (f_item),
    .pop     (1'b1),
    .rd_item (q_item),
    .stat    (q_stat)
  );

  rmq_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_vld         (q_stat.not_empty),
    .in_item        (q_item),
    .out_valid      (out_valid),
    .out_quat_w     (out_quat_w),
    .out_quat_x     (out_quat_x),
    .out_quat_y     (out_quat_y),
    .out_quat_z     (out_quat_z),
    .out_case_taken (out_case_taken),
    .out_degenerate (out_degenerate)
  );

endmodule
